### hw/rtl/iawa_pkg.sv
// Package: shared constants, types and helpers for the inverse affine warp address block.
package iawa_pkg;

  // Image and coordinate geometry
  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 12;
  localparam int DIM_W     = 13;
  localparam int IDX_W     = 24;
  localparam int COEF_W    = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Datapath widths: centered coordinate in half pixels, products, sums
  localparam int UV_W   = DIM_W + 1;
  localparam int PROD_W = COEF_W + UV_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_SH = FRAC_BITS + 1;
  localparam int Q_W    = SUM_W - RND_SH;
  localparam int SRC_W  = Q_W + 1;

  // Reset values
  localparam logic [COEF_W-1:0] ONE_FIXED = COEF_W'(1) << FRAC_BITS;
  localparam logic [DIM_W-1:0]  DIM_RST   = DIM_W'(1024);

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_COEF_XX  = 4'd0,
    REG_COEF_XY  = 4'd1,
    REG_OFFSET_X = 4'd2,
    REG_COEF_YX  = 4'd3,
    REG_COEF_YY  = 4'd4,
    REG_OFFSET_Y = 4'd5,
    REG_WIDTH    = 4'd6,
    REG_HEIGHT   = 4'd7
  } cfg_reg_t;

  // Register file contents seen by the datapath
  typedef struct packed {
    logic signed [COEF_W-1:0] coef_xx;
    logic signed [COEF_W-1:0] coef_xy;
    logic signed [COEF_W-1:0] offset_x;
    logic signed [COEF_W-1:0] coef_yx;
    logic signed [COEF_W-1:0] coef_yy;
    logic signed [COEF_W-1:0] offset_y;
    logic [DIM_W-1:0]         image_width;
    logic [DIM_W-1:0]         image_height;
  } cfg_t;

  // Clamp a dimension to the largest supported image size
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
    return r;
  endfunction

endpackage

### hw/rtl/iawa_if.sv
// Interfaces: destination coordinate, warp result and configuration write channels.
interface iawa_in_if import iawa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] dest_x;
  logic [COORD_W-1:0] dest_y;
  modport source(output valid, dest_x, dest_y, input ready);
  modport sink(input valid, dest_x, dest_y, output ready);
endinterface

interface iawa_out_if import iawa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] src_x;
  logic [COORD_W-1:0] src_y;
  logic [IDX_W-1:0]   src_index;
  logic [IDX_W-1:0]   dst_index;
  logic               in_bounds;
  modport source(output valid, src_x, src_y, src_index, dst_index, in_bounds, input ready);
  modport sink(input valid, src_x, src_y, src_index, dst_index, in_bounds, output ready);
endinterface

interface iawa_cfg_if import iawa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

### hw/rtl/inverse_affine_warp_address_top.sv
// Top level of the inverse affine warp address generator.
//
//   channel  direction  payload
//   in_ch    sink       dest_x, dest_y
//   out_ch   source     src_x, src_y, src_index, dst_index, in_bounds
//   cfg_ch   sink       addr (register index), data
//
// One item per clock while the output is ready; after the input register the result passes
// through the products, sums and rounding registers, and then the output register with the
// bounds check and source index multiply.
// Synchronous active-low reset empties the pipeline and loads the identity matrix,
// zero offsets and a 1024 x 1024 image. A stalled output holds its stage; earlier
// stages keep filling bubbles, so input ready drops only when every stage is full.
module inverse_affine_warp_address_top import iawa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  iawa_in_if.sink    in_ch,
  iawa_out_if.source out_ch,
  iawa_cfg_if.sink   cfg_ch
);

  cfg_t cfg;

  iawa_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  iawa_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Out-of-bounds results carry zero source fields
  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.in_bounds) |->
      (out_ch.src_x == '0 && out_ch.src_y == '0 && out_ch.src_index == '0))
    else $error("out-of-bounds result with nonzero source fields");

  // In-bounds results lie inside the saturated image
  a_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.in_bounds) |->
      (DIM_W'(out_ch.src_x) < sat_dim(cfg.image_width)
       && DIM_W'(out_ch.src_y) < sat_dim(cfg.image_height)))
    else $error("in-bounds source coordinate outside the image");

  // Input back-pressure only comes from a stalled output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled while output is free");

endmodule

### hw/rtl/iawa_cfg_regs.sv
// Configuration register file: matrix, offsets and image size.
module iawa_cfg_regs import iawa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  iawa_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Always ready: a write takes effect in the register file at the next clock edge
  assign cfg_ch.ready = 1'b1;

  // Decode the write; drop writes beyond the register list
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        REG_COEF_XX:  cfg_nxt.coef_xx      = cfg_ch.data;
        REG_COEF_XY:  cfg_nxt.coef_xy      = cfg_ch.data;
        REG_OFFSET_X: cfg_nxt.offset_x     = cfg_ch.data;
        REG_COEF_YX:  cfg_nxt.coef_yx      = cfg_ch.data;
        REG_COEF_YY:  cfg_nxt.coef_yy      = cfg_ch.data;
        REG_OFFSET_Y: cfg_nxt.offset_y     = cfg_ch.data;
        REG_WIDTH:    cfg_nxt.image_width  = cfg_ch.data[DIM_W-1:0];
        REG_HEIGHT:   cfg_nxt.image_height = cfg_ch.data[DIM_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_xx      <= ONE_FIXED;
      cfg_r.coef_xy      <= '0;
      cfg_r.offset_x     <= '0;
      cfg_r.coef_yx      <= '0;
      cfg_r.coef_yy      <= ONE_FIXED;
      cfg_r.offset_y     <= '0;
      cfg_r.image_width  <= DIM_RST;
      cfg_r.image_height <= DIM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/iawa_datapath.sv
// Address pipeline: center, transform, round, bounds check and pixel indices.
module iawa_datapath import iawa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  iawa_in_if.sink    in_ch,
  iawa_out_if.source out_ch
);

  localparam int NSTG = 5;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  // Saturated image size
  logic [DIM_W-1:0] w_sat;
  logic [DIM_W-1:0] h_sat;

  // Stage 1: input register
  logic [COORD_W-1:0] dx_r;
  logic [COORD_W-1:0] dy_r;

  // Stage 2: products and destination index
  logic signed [UV_W-1:0]   u;
  logic signed [UV_W-1:0]   v;
  logic signed [PROD_W-1:0] pxx_nxt, pxy_nxt, pyx_nxt, pyy_nxt;
  logic signed [PROD_W-1:0] pxx_r, pxy_r, pyx_r, pyy_r;
  logic [IDX_W-1:0]         hd;
  logic [IDX_W-1:0]         dst_nxt;
  logic [IDX_W-1:0]         dst2_r, dst3_r, dst4_r;

  // Stage 3: sums in units of 2^-(FRAC_BITS+1) pixel
  logic signed [SUM_W-1:0]  tx_nxt, ty_nxt;
  logic signed [SUM_W-1:0]  tx_r, ty_r;

  // Stage 4: rounded source coordinates
  logic signed [SRC_W-1:0]  sx_nxt, sy_nxt;
  logic signed [SRC_W-1:0]  sx_r, sy_r;

  // Stage 5: output register
  logic                 ok;
  logic [DIM_W-1:0]     hm;
  logic [2*DIM_W-1:0]   sprod;
  logic [IDX_W-1:0]     src_idx_nxt;
  logic [COORD_W-1:0]   src_x_r, src_y_r;
  logic [IDX_W-1:0]     src_idx_r, dst_idx_r;
  logic                 in_bounds_r;

  assign w_sat = sat_dim(cfg.image_width);
  assign h_sat = sat_dim(cfg.image_height);

  // Advance a stage when it is empty or the next one moves
  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int i = NSTG-2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_ch.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_ch.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Centered coordinates in half pixels and the matrix products
  always_comb begin
    u = $signed({1'b0, dx_r, 1'b1}) - $signed(UV_W'(w_sat));
    v = $signed({1'b0, dy_r, 1'b1}) - $signed(UV_W'(h_sat));
    pxx_nxt = cfg.coef_xx * u;
    pxy_nxt = cfg.coef_xy * v;
    pyx_nxt = cfg.coef_yx * u;
    pyy_nxt = cfg.coef_yy * v;
    // Destination index wraps modulo the index width
    hd      = IDX_W'(h_sat) - IDX_W'(1) - IDX_W'(dy_r);
    dst_nxt = IDX_W'(hd * IDX_W'(w_sat)) + IDX_W'(dx_r);
  end

  // Sum the terms and add the image center back
  always_comb begin
    tx_nxt = SUM_W'(pxx_r) + SUM_W'(pxy_r) + (SUM_W'(cfg.offset_x) <<< 1)
           + (SUM_W'(w_sat) << FRAC_BITS);
    ty_nxt = SUM_W'(pyx_r) + SUM_W'(pyy_r) + (SUM_W'(cfg.offset_y) <<< 1)
           + (SUM_W'(h_sat) << FRAC_BITS);
  end

  // Round to nearest, ties to even
  function automatic logic signed [SRC_W-1:0] rnd_even(input logic signed [SUM_W-1:0] t);
    logic signed [Q_W-1:0]  q;
    logic [RND_SH-1:0]      rem;
    logic [RND_SH-1:0]      half;
    logic                   inc;
    q    = t[SUM_W-1:RND_SH];
    rem  = t[RND_SH-1:0];
    half = RND_SH'(1) << (RND_SH-1);
    inc  = (rem > half) || ((rem == half) && q[0]);
    return SRC_W'(q) + SRC_W'(inc);
  endfunction

  assign sx_nxt = rnd_even(tx_r);
  assign sy_nxt = rnd_even(ty_r);

  // Bounds check and source index
  always_comb begin
    ok = !sx_r[SRC_W-1] && !sy_r[SRC_W-1]
      && (sx_r < $signed(SRC_W'(w_sat))) && (sy_r < $signed(SRC_W'(h_sat)));
    hm          = h_sat - DIM_W'(1) - sy_r[DIM_W-1:0];
    sprod       = (2*DIM_W)'(hm) * (2*DIM_W)'(w_sat);
    src_idx_nxt = sprod[IDX_W-1:0] + IDX_W'(sx_r[COORD_W-1:0]);
  end

  // Payload registers, loaded as each stage advances
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx_r <= in_ch.dest_x;
      dy_r <= in_ch.dest_y;
    end
    if (adv[1]) begin
      pxx_r  <= pxx_nxt;
      pxy_r  <= pxy_nxt;
      pyx_r  <= pyx_nxt;
      pyy_r  <= pyy_nxt;
      dst2_r <= dst_nxt;
    end
    if (adv[2]) begin
      tx_r   <= tx_nxt;
      ty_r   <= ty_nxt;
      dst3_r <= dst2_r;
    end
    if (adv[3]) begin
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      dst4_r <= dst3_r;
    end
    if (adv[4]) begin
      src_x_r     <= ok ? sx_r[COORD_W-1:0] : '0;
      src_y_r     <= ok ? sy_r[COORD_W-1:0] : '0;
      src_idx_r   <= ok ? src_idx_nxt : '0;
      dst_idx_r   <= dst4_r;
      in_bounds_r <= ok;
    end
  end

  assign out_ch.valid     = vld_r[NSTG-1];
  assign out_ch.src_x     = src_x_r;
  assign out_ch.src_y     = src_y_r;
  assign out_ch.src_index = src_idx_r;
  assign out_ch.dst_index = dst_idx_r;
  assign out_ch.in_bounds = in_bounds_r;

endmodule

### tb/warp_address_checker.sv
// Checker: watches the warp channels, predicts each source address and compares results.
`timescale 1ns / 1ps

module warp_address_checker import iawa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  iawa_in_if   in_mon,
  iawa_out_if  out_mon,
  iawa_cfg_if  cfg_mon,
  output int   mismatches,
  output int   outstanding,
  output int   results_checked,
  output int   results_in_bounds,
  output int   reg_writes
);

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [IDX_W-1:0]   src_index;
    logic [IDX_W-1:0]   dst_index;
    logic               in_bounds;
  } warp_result_t;

  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    warp_result_t       addr;
  } pending_address_t;

  cfg_t             warp_regs;
  pending_address_t expected_addresses[$];

  // Divide by 2^(FRAC_BITS+1), round to nearest, ties to even
  function automatic longint round_half_even(input longint t);
    longint q;
    longint rem;
    longint half;
    half = longint'(1) <<< (RND_SH - 1);
    q    = t >>> RND_SH;
    rem  = t - (q <<< RND_SH);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    return q;
  endfunction

  // Map one destination pixel back to its nearest source pixel
  function automatic warp_result_t predict_source_address(input cfg_t regs,
                                                          input logic [COORD_W-1:0] dx,
                                                          input logic [COORD_W-1:0] dy);
    warp_result_t r;
    longint w, h, u, v, tx, ty, sx, sy;
    logic ok;
    w = (regs.image_width > DIM_W'(MAX_DIM)) ? longint'(MAX_DIM) : longint'(regs.image_width);
    h = (regs.image_height > DIM_W'(MAX_DIM)) ? longint'(MAX_DIM) : longint'(regs.image_height);
    // centered coordinates in half pixels
    u = 2 * longint'(dx) + 1 - w;
    v = 2 * longint'(dy) + 1 - h;
    tx = longint'($signed(regs.coef_xx)) * u + longint'($signed(regs.coef_xy)) * v
       + 2 * longint'($signed(regs.offset_x)) + (w <<< FRAC_BITS);
    ty = longint'($signed(regs.coef_yx)) * u + longint'($signed(regs.coef_yy)) * v
       + 2 * longint'($signed(regs.offset_y)) + (h <<< FRAC_BITS);
    sx = round_half_even(tx);
    sy = round_half_even(ty);
    ok = (sx >= 0) && (sx < w) && (sy >= 0) && (sy < h);
    r.dst_index = IDX_W'((h - 1 - longint'(dy)) * w + longint'(dx));
    if (ok) begin
      r.src_x     = COORD_W'(sx);
      r.src_y     = COORD_W'(sy);
      r.src_index = IDX_W'((h - 1 - sy) * w + sx);
      r.in_bounds = 1'b1;
    end else begin
      r.src_x     = '0;
      r.src_y     = '0;
      r.src_index = '0;
      r.in_bounds = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string line);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, line);
  endtask

  // Track register writes, queue predictions on input transfers, check result transfers
  always @(posedge clk) begin : monitor
    pending_address_t want;
    warp_result_t     got;
    if (!rst_n) begin
      warp_regs = '{coef_xx: ONE_FIXED, coef_xy: '0, offset_x: '0, coef_yx: '0,
                    coef_yy: ONE_FIXED, offset_y: '0,
                    image_width: DIM_RST, image_height: DIM_RST};
      expected_addresses.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        reg_writes++;
        case (cfg_mon.addr)
          REG_COEF_XX:  warp_regs.coef_xx      = cfg_mon.data;
          REG_COEF_XY:  warp_regs.coef_xy      = cfg_mon.data;
          REG_OFFSET_X: warp_regs.offset_x     = cfg_mon.data;
          REG_COEF_YX:  warp_regs.coef_yx      = cfg_mon.data;
          REG_COEF_YY:  warp_regs.coef_yy      = cfg_mon.data;
          REG_OFFSET_Y: warp_regs.offset_y     = cfg_mon.data;
          REG_WIDTH:    warp_regs.image_width  = cfg_mon.data[DIM_W-1:0];
          REG_HEIGHT:   warp_regs.image_height = cfg_mon.data[DIM_W-1:0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        got.src_x     = out_mon.src_x;
        got.src_y     = out_mon.src_y;
        got.src_index = out_mon.src_index;
        got.dst_index = out_mon.dst_index;
        got.in_bounds = out_mon.in_bounds;
        if (expected_addresses.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: src=(%0d,%0d) dst_index=%0d",
                                    got.src_x, got.src_y, got.dst_index));
        end else begin
          want = expected_addresses.pop_front();
          results_checked++;
          if (want.addr.in_bounds) results_in_bounds++;
          if (got.src_x !== want.addr.src_x)
            report_mismatch($sformatf("dest (%0d,%0d) src_x got %0d want %0d", want.dest_x,
                                      want.dest_y, got.src_x, want.addr.src_x));
          if (got.src_y !== want.addr.src_y)
            report_mismatch($sformatf("dest (%0d,%0d) src_y got %0d want %0d", want.dest_x,
                                      want.dest_y, got.src_y, want.addr.src_y));
          if (got.src_index !== want.addr.src_index)
            report_mismatch($sformatf("dest (%0d,%0d) src_index got %0d want %0d", want.dest_x,
                                      want.dest_y, got.src_index, want.addr.src_index));
          if (got.dst_index !== want.addr.dst_index)
            report_mismatch($sformatf("dest (%0d,%0d) dst_index got %0d want %0d", want.dest_x,
                                      want.dest_y, got.dst_index, want.addr.dst_index));
          if (got.in_bounds !== want.addr.in_bounds)
            report_mismatch($sformatf("dest (%0d,%0d) in_bounds got %0b want %0b", want.dest_x,
                                      want.dest_y, got.in_bounds, want.addr.in_bounds));
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        want.dest_x = in_mon.dest_x;
        want.dest_y = in_mon.dest_y;
        want.addr   = predict_source_address(warp_regs, in_mon.dest_x, in_mon.dest_y);
        expected_addresses.push_back(want);
      end
    end
    outstanding = expected_addresses.size();
  end

endmodule

### tb/inverse_affine_warp_address_top_test.sv
// Testbench top: drives coordinates and register writes into the warp block and gives the verdict.
`timescale 1ns / 1ps

module inverse_affine_warp_address_top_test import iawa_pkg::*; ();

  localparam int                    TIMEOUT_NS    = 2_000_000;
  localparam int                    RANDOM_PHASES = 10;
  localparam int                    PHASE_ITEMS   = 80;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED    = 4'hC;

  logic clk;
  logic rst_n;

  iawa_in_if  in_ch();
  iawa_out_if out_ch();
  iawa_cfg_if cfg_ch();

  int   mismatches, outstanding, results_checked, results_in_bounds, reg_writes;
  int   settings_run;
  logic steady;
  cfg_t warp_cfg;

  inverse_affine_warp_address_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  warp_address_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mon            (in_ch),
    .out_mon           (out_ch),
    .cfg_mon           (cfg_ch),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .results_checked   (results_checked),
    .results_in_bounds (results_in_bounds),
    .reg_writes        (reg_writes)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stall the result channel: mostly short stalls, a few long ones, some long open stretches
  initial begin
    int   r;
    int   len;
    logic lvl;
    out_ch.ready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        lvl = 1'b1; len = $urandom_range(1, 16);
      end else if (r < 80) begin
        lvl = 1'b0; len = $urandom_range(1, 3);
      end else if (r < 92) begin
        lvl = 1'b0; len = $urandom_range(4, 12);
      end else if (r < 96) begin
        lvl = 1'b0; len = $urandom_range(20, 40);
      end else begin
        lvl = 1'b1; len = $urandom_range(100, 300);
      end
      @(negedge clk);
      out_ch.ready = lvl;
      repeat (len - 1) @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return DIM_W'($urandom_range(1, 64));
    if (r < 75) return DIM_W'($urandom_range(65, MAX_DIM));
    if (r < 85) return $urandom_range(0, 1) ? DIM_W'(1) : DIM_W'(MAX_DIM);
    if (r < 95) return DIM_W'($urandom_range(MAX_DIM + 1, (1 << DIM_W) - 1));
    return '0;
  endfunction

  // Mostly inside the image, sometimes anywhere in the coordinate range
  function automatic logic [COORD_W-1:0] pick_dest(input logic [DIM_W-1:0] dim);
    int lim;
    lim = (dim > DIM_W'(MAX_DIM)) ? MAX_DIM : int'(dim);
    if (lim == 0 || $urandom_range(0, 99) < 15) return COORD_W'($urandom());
    return COORD_W'($urandom_range(0, lim - 1));
  endfunction

  // Signed fixed-point value in [-lim, lim]
  function automatic logic [COEF_W-1:0] rand_fix(input int lim);
    return COEF_W'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic logic [COEF_W-1:0] unit_fix();
    return $urandom_range(0, 1) ? ONE_FIXED : -ONE_FIXED;
  endfunction

  function automatic cfg_t random_warp();
    cfg_t c;
    int   r;
    int   wl;
    int   hl;
    c.image_width  = pick_dim();
    c.image_height = pick_dim();
    wl = (c.image_width > DIM_W'(MAX_DIM)) ? MAX_DIM : int'(c.image_width);
    hl = (c.image_height > DIM_W'(MAX_DIM)) ? MAX_DIM : int'(c.image_height);
    r  = $urandom_range(0, 9);
    if (r < 4) begin
      // general scale, shear and rotation within +-2.0
      c.coef_xx  = rand_fix(1 << 17);
      c.coef_xy  = rand_fix(1 << 17);
      c.coef_yx  = rand_fix(1 << 17);
      c.coef_yy  = rand_fix(1 << 17);
      c.offset_x = rand_fix(wl << 15);
      c.offset_y = rand_fix(hl << 15);
    end else if (r < 6) begin
      // quarter-step coefficients and half-pixel offsets land on exact ties
      c.coef_xx  = COEF_W'((int'($urandom_range(0, 16)) - 8) * 'h4000);
      c.coef_xy  = COEF_W'((int'($urandom_range(0, 16)) - 8) * 'h4000);
      c.coef_yx  = COEF_W'((int'($urandom_range(0, 16)) - 8) * 'h4000);
      c.coef_yy  = COEF_W'((int'($urandom_range(0, 16)) - 8) * 'h4000);
      c.offset_x = COEF_W'((int'($urandom_range(0, 64)) - 32) * 'h8000);
      c.offset_y = COEF_W'((int'($urandom_range(0, 64)) - 32) * 'h8000);
    end else if (r < 8) begin
      // mirrors and quarter turns with a shift
      if ($urandom_range(0, 1)) begin
        c.coef_xx = unit_fix(); c.coef_xy = '0; c.coef_yx = '0; c.coef_yy = unit_fix();
      end else begin
        c.coef_xx = '0; c.coef_xy = unit_fix(); c.coef_yx = unit_fix(); c.coef_yy = '0;
      end
      c.offset_x = rand_fix(wl << 16);
      c.offset_y = rand_fix(hl << 16);
    end else begin
      c.coef_xx  = $urandom();
      c.coef_xy  = $urandom();
      c.coef_yx  = $urandom();
      c.coef_yy  = $urandom();
      c.offset_x = $urandom();
      c.offset_y = $urandom();
    end
    return c;
  endfunction

  // Hold off the sender until every pending result has been transferred
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.addr  = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Load a full register set once the pipeline is empty
  task automatic program_warp(input cfg_t c);
    wait_drained();
    write_reg(REG_COEF_XX, c.coef_xx);
    write_reg(REG_COEF_XY, c.coef_xy);
    write_reg(REG_OFFSET_X, c.offset_x);
    write_reg(REG_COEF_YX, c.coef_yx);
    write_reg(REG_COEF_YY, c.coef_yy);
    write_reg(REG_OFFSET_Y, c.offset_y);
    write_reg(REG_WIDTH, {19'($urandom()), c.image_width});
    write_reg(REG_HEIGHT, {19'($urandom()), c.image_height});
    settings_run++;
  endtask

  // Offer one coordinate, hold it until the transfer, then maybe idle
  task automatic send_coord(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int gap;
    in_ch.valid  = 1'b1;
    in_ch.dest_x = x;
    in_ch.dest_y = y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    int ph;
    int n;
    rst_n        = 1'b0;
    steady       = 1'b0;
    settings_run = 1;
    in_ch.valid  = 1'b0;
    in_ch.dest_x = '0;
    in_ch.dest_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr  = REG_COEF_XX;
    cfg_ch.data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: identity on a 1024 x 1024 image, corners and outside points
    send_coord(12'd0, 12'd0);
    send_coord(12'd1023, 12'd1023);
    send_coord(12'd4095, 12'd4095);
    send_coord(12'd0, 12'd4095);
    send_coord(12'd4095, 12'd0);
    send_coord(12'd512, 12'd511);

    // Constant source at exact halfway points: 2.5 and 1.5 round to even
    warp_cfg = '{coef_xx: '0, coef_xy: '0, offset_x: 32'h0000_8000, coef_yx: '0,
                 coef_yy: '0, offset_y: 32'hFFFF_8000, image_width: 13'd4, image_height: 13'd4};
    program_warp(warp_cfg);
    write_reg(REG_UNUSED, $urandom());
    send_coord(12'd0, 12'd0);
    send_coord(12'd3, 12'd3);

    // Extreme coefficients and offsets, dimensions above the maximum
    warp_cfg = '{coef_xx: 32'h7FFF_FFFF, coef_xy: 32'h8000_0000, offset_x: 32'h8000_0000,
                 coef_yx: 32'h8000_0000, coef_yy: 32'h7FFF_FFFF, offset_y: 32'h7FFF_FFFF,
                 image_width: 13'h1FFF, image_height: 13'd5000};
    program_warp(warp_cfg);
    send_coord(12'd0, 12'd0);
    send_coord(12'd4095, 12'd4095);
    send_coord(12'd2048, 12'd2047);

    // Zero-sized image: nothing is ever in bounds
    warp_cfg = '{coef_xx: ONE_FIXED, coef_xy: '0, offset_x: '0, coef_yx: '0,
                 coef_yy: ONE_FIXED, offset_y: '0, image_width: '0, image_height: '0};
    program_warp(warp_cfg);
    send_coord(12'd0, 12'd0);
    send_coord(12'd5, 12'd7);

    // Single pixel image: the center of pixel zero is a tie
    warp_cfg.image_width  = 13'd1;
    warp_cfg.image_height = 13'd1;
    program_warp(warp_cfg);
    send_coord(12'd0, 12'd0);
    send_coord(12'd1, 12'd1);

    // Largest image, mirrored on both axes
    warp_cfg = '{coef_xx: -ONE_FIXED, coef_xy: '0, offset_x: '0, coef_yx: '0,
                 coef_yy: -ONE_FIXED, offset_y: '0, image_width: DIM_W'(MAX_DIM),
                 image_height: DIM_W'(MAX_DIM)};
    program_warp(warp_cfg);
    send_coord(12'd0, 12'd0);
    send_coord(12'd4095, 12'd4095);
    send_coord(12'd100, 12'd200);

    // Random settings, each followed by a series of random coordinates
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      warp_cfg = random_warp();
      program_warp(warp_cfg);
      steady = ($urandom_range(0, 4) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ((ph == 0 && n == PHASE_ITEMS / 2) || $urandom_range(0, 99) == 0) wait_drained();
        send_coord(pick_dest(warp_cfg.image_width), pick_dest(warp_cfg.image_height));
      end
    end

    // Drain, let the pipeline settle, then report
    wait_drained();
    repeat (20) @(negedge clk);
    $display("Summary: %0d results checked (%0d in bounds) over %0d settings, %0d reg writes",
             results_checked, results_in_bounds, settings_run, reg_writes);
    $display("Summary: includes ties, saturated and zero sizes, outside points, full drains");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
